// ----- src/taps_pkg.sv -----
// Shared definitions for the two-anchor position solver.
// Holds the status codes and default constants; no dependencies.
package taps_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam logic [7:0] AVG_COUNT_RESET = 8'd1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_COINCIDE = 2'd1,
    ST_NO_MEET  = 2'd2
  } status_t;

endpackage

// ----- src/taps_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; used by the position solver for all of its divisions.
module taps_div #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int QW = 8,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [PW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [PW-1:0] out_side
);

  // The quotient is known to fit in QW bits, so the bits of the dividend
  // above QW start out as a partial remainder below the divisor.
  logic [QW-1:0] v;
  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] work_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [PW-1:0] side_q [QW];
  logic [DW-1:0] rem_next [QW];
  logic [QW-1:0] work_next [QW];

  always_comb begin
    logic [DW-1:0] cur_rem;
    logic [QW-1:0] cur_work;
    logic [DW-1:0] cur_den;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        cur_rem  = DW'(num >> QW);
        cur_work = num[QW-1:0];
        cur_den  = den;
      end else begin
        cur_rem  = rem_q[k-1];
        cur_work = work_q[k-1];
        cur_den  = den_q[k-1];
      end
      trial        = {cur_rem, cur_work[QW-1]};
      diff         = trial - {1'b0, cur_den};
      take         = !diff[DW];
      rem_next[k]  = take ? diff[DW-1:0] : trial[DW-1:0];
      work_next[k] = (cur_work << 1) | QW'(take);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= QW'({v, in_valid});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_q[0]  <= den;
      side_q[0] <= in_side;
      for (int k = 1; k < QW; k++) begin
        den_q[k]  <= den_q[k-1];
        side_q[k] <= side_q[k-1];
      end
      for (int k = 0; k < QW; k++) begin
        rem_q[k]  <= rem_next[k];
        work_q[k] <= work_next[k];
      end
    end
  end

  assign out_valid = v[QW-1];
  assign quo       = work_q[QW-1];
  assign out_side  = side_q[QW-1];

endmodule

// ----- src/taps_sqrt.sv -----
// Pipelined integer square root (floor), one result bit per register stage.
// Standalone; used by the position solver for d and h.
module taps_sqrt #(
  parameter int RW = 8,
  parameter int PW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] rad,
  input  logic [PW-1:0]   in_side,
  output logic            out_valid,
  output logic [RW-1:0]   root,
  output logic [PW-1:0]   out_side
);

  logic [RW-1:0]   v;
  logic [RW+1:0]   rem_q [RW];
  logic [RW-1:0]   root_q [RW];
  logic [2*RW-1:0] work_q [RW];
  logic [PW-1:0]   side_q [RW];
  logic [RW+1:0]   rem_next [RW];
  logic [RW-1:0]   root_next [RW];
  logic [2*RW-1:0] work_next [RW];

  always_comb begin
    logic [RW+1:0]   cur_rem;
    logic [RW-1:0]   cur_root;
    logic [2*RW-1:0] cur_work;
    logic [RW+1:0]   trial_rem;
    logic [RW+1:0]   trial_sub;
    logic [RW+2:0]   diff;
    logic            take;
    for (int k = 0; k < RW; k++) begin
      if (k == 0) begin
        cur_rem  = '0;
        cur_root = '0;
        cur_work = rad;
      end else begin
        cur_rem  = rem_q[k-1];
        cur_root = root_q[k-1];
        cur_work = work_q[k-1];
      end
      // Bring down the next two radicand bits and try root*4+1.
      trial_rem    = {cur_rem[RW-1:0], cur_work[2*RW-1 -: 2]};
      trial_sub    = {cur_root, 2'b01};
      diff         = {1'b0, trial_rem} - {1'b0, trial_sub};
      take         = !diff[RW+2];
      rem_next[k]  = take ? diff[RW+1:0] : trial_rem;
      root_next[k] = (cur_root << 1) | RW'(take);
      work_next[k] = cur_work << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= RW'({v, in_valid});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= in_side;
      for (int k = 1; k < RW; k++) begin
        side_q[k] <= side_q[k-1];
      end
      for (int k = 0; k < RW; k++) begin
        rem_q[k]  <= rem_next[k];
        root_q[k] <= root_next[k];
        work_q[k] <= work_next[k];
      end
    end
  end

  assign out_valid = v[RW-1];
  assign root      = root_q[RW-1];
  assign out_side  = side_q[RW-1];

endmodule

// ----- src/two_anchor_position_solve.sv -----
// Two-anchor position solver: circle-circle intersection in fixed point.
// Depends on taps_pkg, taps_div and taps_sqrt.
//
// Usage: each item on the s_ channel carries two anchor positions and the
// summed range readings to each anchor. The block divides both sums by the
// averaging count, intersects the two circles and returns one item on the
// m_ channel with the rounded, saturated position and a status code (ok,
// anchors coincide, circles do not meet). A failed solve reports 0, 0.
// The averaging count is written on the cfg_ channel, which is always ready;
// write it only while no item is in flight. A count of zero acts as one.
// The pipeline chains bit-serial pipelined units (range divide, square root
// for d, divide for a, square root for h, offset divides) with register
// stages between them. Throughput is one item per cycle while the receiver
// does not stall; every stage is a register and valid bits travel with the
// data. When the receiver stalls the whole pipeline holds in place and
// s_tready drops, so nothing is lost or repeated. Reset clears all valid
// bits and sets the averaging count back to one.
module two_anchor_position_solve import taps_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data,    // average_count
  input  logic         s_tvalid,
  output logic         s_tready,
  // anchor_a_x, anchor_a_y, anchor_b_x, anchor_b_y, range_sum_a, range_sum_b
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [55:0]  m_tdata      // pos_x, pos_y, status, zero fill
);

  localparam int F    = FRACTION_BITS;
  localparam int DFW  = 25 + F;         // d with F fraction bits
  localparam int ANW  = 50 + 2 * F;     // |N| scaled for the a divide
  localparam int AQW  = 49 + F;         // a before the range check
  localparam int AW   = 24 + F;         // a and h after the range check
  localparam int KL   = (25 + F) / 2;   // low half of a for squaring
  localparam int KH   = AW - KL;
  localparam int RADW = 2 * AW;         // r1f^2 - af^2
  localparam int PHW  = KH + 27;        // high half of a or h times a difference
  localparam int PLW  = KL + 27;        // low half of a or h times a difference
  localparam int TSW  = 52 + F;
  localparam int TMW  = 50 + F;
  localparam int TNW  = 50 + 2 * F;
  localparam int TQW  = 26 + F;
  localparam int SW   = 28 + F;

  typedef struct packed {
    logic signed [23:0] ax;
    logic signed [23:0] ay;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
  } geo_t;

  typedef struct packed {
    logic signed [50:0] n;
    logic               zero;
    logic [47:0]        r1sq;
    logic [23:0]        r1;
    geo_t               geo;
  } dside_t;

  typedef struct packed {
    logic           an;
    logic           zero;
    logic [47:0]    r1sq;
    logic [23:0]    r1;
    geo_t           geo;
    logic [DFW-1:0] df;
  } aside_t;

  typedef struct packed {
    logic [AW-1:0]      afl;
    status_t            st;
    geo_t               geo;
    logic signed [25:0] sdx;
    logic signed [25:0] sdy;
    logic [DFW-1:0]     df;
  } hside_t;

  typedef struct packed {
    logic signed [23:0] ax;
    logic signed [23:0] ay;
    logic               txn;
    logic               tyn;
    status_t            st;
  } fside_t;

  // Global advance: every stage moves when the output slot is free.
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign cfg_ready = 1'b1;

  logic [7:0] avg_count;
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_count <= AVG_COUNT_RESET;
    end else if (cfg_valid) begin
      avg_count <= cfg_data;
    end
  end

  // Stage A: anchor differences and divisor.
  logic        va;
  geo_t        a_geo;
  logic [23:0] a_sa, a_sb;
  logic [7:0]  a_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_geo.ax <= s_tdata[23:0];
      a_geo.ay <= s_tdata[47:24];
      a_geo.dx <= $signed({s_tdata[71], s_tdata[71:48]}) - $signed({s_tdata[23], s_tdata[23:0]});
      a_geo.dy <= $signed({s_tdata[95], s_tdata[95:72]}) - $signed({s_tdata[47], s_tdata[47:24]});
      a_sa     <= s_tdata[119:96];
      a_sb     <= s_tdata[143:120];
      a_div    <= (avg_count == 8'd0) ? 8'd1 : avg_count;
    end
  end

  // Range averages.
  logic        r_valid;
  logic [23:0] r1, r2;
  geo_t        r_geo;

  taps_div #(.NW(24), .DW(8), .QW(24), .PW($bits(geo_t))) u_div_r1 (
    .clk, .rst, .en(adv), .in_valid(va), .num(a_sa), .den(a_div), .in_side(a_geo),
    .out_valid(r_valid), .quo(r1), .out_side(r_geo)
  );

  taps_div #(.NW(24), .DW(8), .QW(24), .PW(1)) u_div_r2 (
    .clk, .rst, .en(adv), .in_valid(va), .num(a_sb), .den(a_div), .in_side(1'b0),
    .out_valid(), .quo(r2), .out_side()
  );

  // Stage B: squares.
  logic               vb;
  geo_t               b_geo;
  logic signed [49:0] b_dxsq, b_dysq;
  logic [47:0]        b_r1sq, b_r2sq;
  logic [23:0]        b_r1;

  // Stage C: squared distance and r1^2 - r2^2.
  logic               vc;
  geo_t               c_geo;
  logic [49:0]        c_d2;
  logic signed [50:0] c_r12;
  logic [47:0]        c_r1sq;
  logic [23:0]        c_r1;

  // Stage C2: N and the coincidence flag.
  logic   vc2;
  dside_t c2_side;
  logic [49:0] c2_d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb  <= 1'b0;
      vc  <= 1'b0;
      vc2 <= 1'b0;
    end else if (adv) begin
      vb  <= r_valid;
      vc  <= vb;
      vc2 <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_geo  <= r_geo;
      b_dxsq <= r_geo.dx * r_geo.dx;
      b_dysq <= r_geo.dy * r_geo.dy;
      b_r1sq <= r1 * r1;
      b_r2sq <= r2 * r2;
      b_r1   <= r1;

      c_geo  <= b_geo;
      c_d2   <= $unsigned(b_dxsq) + $unsigned(b_dysq);
      c_r12  <= $signed({3'b000, b_r1sq}) - $signed({3'b000, b_r2sq});
      c_r1sq <= b_r1sq;
      c_r1   <= b_r1;

      c2_side.n    <= c_r12 + $signed({1'b0, c_d2});
      c2_side.zero <= (c_d2 == 50'd0);
      c2_side.r1sq <= c_r1sq;
      c2_side.r1   <= c_r1;
      c2_side.geo  <= c_geo;
      c2_d2        <= c_d2;
    end
  end

  // d = sqrt(D2) with F fraction bits.
  logic           d_valid;
  logic [DFW-1:0] df;
  dside_t         d_side;

  taps_sqrt #(.RW(DFW), .PW($bits(dside_t))) u_sqrt_d (
    .clk, .rst, .en(adv), .in_valid(vc2), .rad({c2_d2, {(2 * F){1'b0}}}),
    .in_side(c2_side), .out_valid(d_valid), .root(df), .out_side(d_side)
  );

  // Stage D: magnitude of N for the a divide.
  logic        vd;
  logic [49:0] d_nmag;
  aside_t      d_aside;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (adv) begin
      vd <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_nmag       <= d_side.n[50] ? 50'(-d_side.n) : d_side.n[49:0];
      d_aside.an   <= d_side.n[50];
      d_aside.zero <= d_side.zero;
      d_aside.r1sq <= d_side.r1sq;
      d_aside.r1   <= d_side.r1;
      d_aside.geo  <= d_side.geo;
      d_aside.df   <= df;
    end
  end

  // a = |N| * 2^2F / (2 df).
  logic           af_valid;
  logic [AQW-1:0] af_full;
  aside_t         af_side;

  taps_div #(.NW(ANW), .DW(DFW + 1), .QW(AQW), .PW($bits(aside_t))) u_div_a (
    .clk, .rst, .en(adv), .in_valid(vd), .num({d_nmag, {(2 * F){1'b0}}}),
    .den({d_aside.df, 1'b0}), .in_side(d_aside),
    .out_valid(af_valid), .quo(af_full), .out_side(af_side)
  );

  // Stage E: range check and partial squares of a.
  logic               ve;
  logic [2*KH-1:0]    e_hh;
  logic [KH+KL-1:0]   e_hl;
  logic [2*KL-1:0]    e_ll;
  logic [AW-1:0]      e_afl;
  logic               e_an;
  status_t            e_st;
  logic [47:0]        e_r1sq;
  geo_t               e_geo;
  logic [DFW-1:0]     e_df;

  // Stage E2: a^2.
  logic               ve2;
  logic [RADW-1:0]    e2_asq;
  logic [AW-1:0]      e2_afl;
  logic               e2_an;
  status_t            e2_st;
  logic [47:0]        e2_r1sq;
  geo_t               e2_geo;
  logic [DFW-1:0]     e2_df;

  // Stage F: r1f^2 - a^2 and the signed anchor differences for a's sign.
  logic               vf;
  logic [RADW-1:0]    f_rad;
  hside_t             f_side;

  logic [AW-1:0] afl_w;
  assign afl_w = af_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ve  <= 1'b0;
      ve2 <= 1'b0;
      vf  <= 1'b0;
    end else if (adv) begin
      ve  <= af_valid;
      ve2 <= ve;
      vf  <= ve2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_hh   <= afl_w[AW-1:KL] * afl_w[AW-1:KL];
      e_hl   <= afl_w[AW-1:KL] * afl_w[KL-1:0];
      e_ll   <= afl_w[KL-1:0] * afl_w[KL-1:0];
      e_afl  <= afl_w;
      e_an   <= af_side.an;
      if (af_side.zero) begin
        e_st <= ST_COINCIDE;
      end else if (af_full > AQW'({af_side.r1, {F{1'b0}}})) begin
        e_st <= ST_NO_MEET;
      end else begin
        e_st <= ST_OK;
      end
      e_r1sq <= af_side.r1sq;
      e_geo  <= af_side.geo;
      e_df   <= af_side.df;

      e2_asq  <= (RADW'(e_hh) << (2 * KL)) + (RADW'(e_hl) << (KL + 1)) + RADW'(e_ll);
      e2_afl  <= e_afl;
      e2_an   <= e_an;
      e2_st   <= e_st;
      e2_r1sq <= e_r1sq;
      e2_geo  <= e_geo;
      e2_df   <= e_df;

      f_rad      <= {e2_r1sq, {(2 * F){1'b0}}} - e2_asq;
      f_side.afl <= e2_afl;
      f_side.st  <= e2_st;
      f_side.geo <= e2_geo;
      f_side.sdx <= e2_an ? -26'(e2_geo.dx) : 26'(e2_geo.dx);
      f_side.sdy <= e2_an ? -26'(e2_geo.dy) : 26'(e2_geo.dy);
      f_side.df  <= e2_df;
    end
  end

  // h = sqrt(r1f^2 - a^2).
  logic          h_valid;
  logic [AW-1:0] hf;
  hside_t        h_side;

  taps_sqrt #(.RW(AW), .PW($bits(hside_t))) u_sqrt_h (
    .clk, .rst, .en(adv), .in_valid(vf), .rad(f_rad), .in_side(f_side),
    .out_valid(h_valid), .root(hf), .out_side(h_side)
  );

  // Stage G: products. Stage H: offset numerators. Stage I: magnitudes.
  // a and h are split into the same high and low halves as for a^2, so each
  // product stays a narrow multiplier; stage H adds the halves back together.
  logic                  vg, vh, vi;
  logic signed [PHW-1:0] g_p1h, g_p2h, g_p3h, g_p4h;
  logic signed [PLW-1:0] g_p1l, g_p2l, g_p3l, g_p4l;
  logic signed [TSW-1:0] h_tx, h_ty;
  logic [TMW-1:0]        i_txm, i_tym;
  fside_t                g_fs, h_fs, i_fs;
  logic [DFW-1:0]        g_df, h_df, i_df;

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
      vh <= 1'b0;
      vi <= 1'b0;
    end else if (adv) begin
      vg <= h_valid;
      vh <= vg;
      vi <= vh;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_p1h    <= $signed({1'b0, h_side.afl[AW-1:KL]}) * h_side.sdx;
      g_p1l    <= $signed({1'b0, h_side.afl[KL-1:0]}) * h_side.sdx;
      g_p2h    <= $signed({1'b0, hf[AW-1:KL]}) * h_side.geo.dy;
      g_p2l    <= $signed({1'b0, hf[KL-1:0]}) * h_side.geo.dy;
      g_p3h    <= $signed({1'b0, h_side.afl[AW-1:KL]}) * h_side.sdy;
      g_p3l    <= $signed({1'b0, h_side.afl[KL-1:0]}) * h_side.sdy;
      g_p4h    <= $signed({1'b0, hf[AW-1:KL]}) * h_side.geo.dx;
      g_p4l    <= $signed({1'b0, hf[KL-1:0]}) * h_side.geo.dx;
      g_fs.ax  <= h_side.geo.ax;
      g_fs.ay  <= h_side.geo.ay;
      g_fs.txn <= 1'b0;
      g_fs.tyn <= 1'b0;
      g_fs.st  <= h_side.st;
      g_df     <= h_side.df;

      h_tx <= (TSW'(g_p1h) <<< KL) + TSW'(g_p1l) + (TSW'(g_p2h) <<< KL) + TSW'(g_p2l);
      h_ty <= (TSW'(g_p3h) <<< KL) + TSW'(g_p3l) - (TSW'(g_p4h) <<< KL) - TSW'(g_p4l);
      h_fs <= g_fs;
      h_df <= g_df;

      i_txm     <= h_tx[TSW-1] ? TMW'(-h_tx) : TMW'(h_tx);
      i_tym     <= h_ty[TSW-1] ? TMW'(-h_ty) : TMW'(h_ty);
      i_fs.ax   <= h_fs.ax;
      i_fs.ay   <= h_fs.ay;
      i_fs.txn  <= h_tx[TSW-1];
      i_fs.tyn  <= h_ty[TSW-1];
      i_fs.st   <= h_fs.st;
      i_df      <= h_df;
    end
  end

  // Offsets: numerator * 2^F / df, truncated on magnitudes.
  logic           q_valid;
  logic [TQW-1:0] qx, qy;
  fside_t         q_fs;

  taps_div #(.NW(TNW), .DW(DFW), .QW(TQW), .PW($bits(fside_t))) u_div_x (
    .clk, .rst, .en(adv), .in_valid(vi), .num({i_txm, {F{1'b0}}}), .den(i_df),
    .in_side(i_fs), .out_valid(q_valid), .quo(qx), .out_side(q_fs)
  );

  taps_div #(.NW(TNW), .DW(DFW), .QW(TQW), .PW(1)) u_div_y (
    .clk, .rst, .en(adv), .in_valid(vi), .num({i_tym, {F{1'b0}}}), .den(i_df),
    .in_side(1'b0), .out_valid(), .quo(qy), .out_side()
  );

  // Stage J: anchor plus signed offset, F fraction bits.
  logic                vj;
  logic signed [SW-1:0] j_sx, j_sy;
  status_t             j_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      vj <= 1'b0;
    end else if (adv) begin
      vj <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j_sx <= q_fs.txn
        ? $signed({{4{q_fs.ax[23]}}, q_fs.ax, {F{1'b0}}}) - $signed({2'b00, qx})
        : $signed({{4{q_fs.ax[23]}}, q_fs.ax, {F{1'b0}}}) + $signed({2'b00, qx});
      j_sy <= q_fs.tyn
        ? $signed({{4{q_fs.ay[23]}}, q_fs.ay, {F{1'b0}}}) - $signed({2'b00, qy})
        : $signed({{4{q_fs.ay[23]}}, q_fs.ay, {F{1'b0}}}) + $signed({2'b00, qy});
      j_st <= q_fs.st;
    end
  end

  // Stage K (output register): round half away from zero and saturate.
  // For a negative value, adding half minus one and flooring gives the same
  // result as rounding the magnitude.
  localparam logic [SW-1:0] HALF = SW'(1) << (F - 1);

  logic signed [SW-1:0] rnd_x, rnd_y;
  logic signed [27:0]   rs_x, rs_y;
  logic [23:0]          px, py;

  assign rnd_x = j_sx + $signed(j_sx[SW-1] ? HALF - SW'(1) : HALF);
  assign rnd_y = j_sy + $signed(j_sy[SW-1] ? HALF - SW'(1) : HALF);
  assign rs_x  = rnd_x[SW-1:F];
  assign rs_y  = rnd_y[SW-1:F];

  always_comb begin
    if (rs_x > 28'sd8388607) begin
      px = 24'h7FFFFF;
    end else if (rs_x < -28'sd8388608) begin
      px = 24'h800000;
    end else begin
      px = rs_x[23:0];
    end
    if (rs_y > 28'sd8388607) begin
      py = 24'h7FFFFF;
    end else if (rs_y < -28'sd8388608) begin
      py = 24'h800000;
    end else begin
      py = rs_y[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= vj;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (j_st == ST_OK) begin
        m_tdata <= {6'd0, j_st, py, px};
      end else begin
        m_tdata <= {6'd0, j_st, 48'd0};
      end
    end
  end

`ifndef SYNTH
  a_coincide_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[49:48] == ST_COINCIDE) |-> (m_tdata[47:0] == 48'd0))
    else $error("coinciding anchors gave a nonzero position");

  a_no_meet_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[49:48] == ST_NO_MEET) |-> (m_tdata[47:0] == 48'd0))
    else $error("non-intersecting circles gave a nonzero position");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(vj) && $stable(j_sx) && $stable(j_st)))
    else $error("last pipeline stage moved during a stall");
`endif

endmodule
